### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DUCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ducs assertion failed");

// next-cycle implication
`define DUCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ducs assertion failed");

`endif

### hw/rtl/ducs_pkg.sv
// types, constants and tables of the up/down counter with display scan
`default_nettype none
package ducs_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int ENABLE_W    = 4;
   localparam int COUNT_W     = 14;
   localparam int LOAD_W      = 16;
   localparam int SEG_W       = 7;
   localparam int TICKS_W     = 8;
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 24;
   localparam int DIV10_W     = 13;
   localparam int DIV10_SHIFT = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = 14'd9999;
   localparam logic [TICKS_W-1:0] DEBOUNCE_RESET  = 8'd40;
   localparam logic [TICKS_W-1:0] SCAN_RESET      = 8'd2;
   localparam logic [DIV10_W-1:0] DIV10_RECIP     = 13'd6554;

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_LOAD = 1'b1
   } req_kind_type;

   typedef enum logic {
      REG_DEBOUNCE = 1'b0,
      REG_SCAN     = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      PH_RELEASED      = 4'b0001,
      PH_PRESS_CHECK   = 4'b0010,
      PH_PRESSED       = 4'b0100,
      PH_RELEASE_CHECK = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [TICKS_W-1:0] debounce_ticks;
      logic [TICKS_W-1:0] scan_ticks;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic                save;
      logic                lit;
      logic [POS_W-1:0]    pos;
      logic [ENABLE_W-1:0] enable;
      logic [COUNT_W-1:0]  shown;
   } s1_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic                save;
      logic                lit;
      logic [ENABLE_W-1:0] enable;
      logic [COUNT_W-1:0]  quot;
   } s2_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               pending;
   } stat_type;

   // segments a..g in bits 0..6
   function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0:    seg = 7'd63;
         4'd1:    seg = 7'd6;
         4'd2:    seg = 7'd91;
         4'd3:    seg = 7'd79;
         4'd4:    seg = 7'd102;
         4'd5:    seg = 7'd109;
         4'd6:    seg = 7'd125;
         4'd7:    seg = 7'd7;
         4'd8:    seg = 7'd127;
         4'd9:    seg = 7'd111;
         default: seg = '0;
      endcase
      return seg;
   endfunction

   // 2^24 / 10^pos rounded up, zero past the thousands
   function automatic logic [RECIP_W-1:0] recip_of(input logic [POS_W-1:0] pos);
      logic [RECIP_W-1:0] r;
      case (int'(pos))
         0:       r = 25'd16777216;
         1:       r = 25'd1677722;
         2:       r = 25'd167773;
         3:       r = 25'd16778;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/debounced_updown_counter_7seg_scan.sv
// four-digit up/down counter with button debounce and display scan
//
// each req word is one millisecond tick carrying the raw levels of the up and
// down buttons (active low), or a load that restores the count (values above
// 9999 load as zero). every req word yields exactly one rsp word: the segment
// pattern and one-hot enable of the digit lit now, the count after the word
// and a save flag set when a button moved the count.
// each rsp word passes three registers: a state/first register, a register
// after the divide-by-power-of-ten multiplier, and the result register after
// the modulo-ten and segment lookup. one word is taken per cycle while the
// pipeline is not held by a low rsp_tready; all counter, debounce and scan
// state is updated in the cycle the word is taken.
// when rsp_tready is low the result register holds and empty stages ahead of
// it keep filling, so req_tready drops only once all three stages are full.
// reset clears the count, the display (dark, no digit enabled), both
// debouncers to released, and sets the periods to 40 and 2 ticks.
// the csr port holds the debounce period at 0x0 and the scan period at 0x4;
// write them only while no word is in flight.
`default_nettype none
`include "assert_macros.svh"
module debounced_updown_counter_7seg_scan import ducs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // button_up_level[0], button_down_level[1], load_value[17:2], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // segment_pattern[6:0], digit_enable[10:7], count_now[24:11],
   // save_request[25], zero fill
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type             cfg;
   stat_type            stat;
   s1_type              s1_data;
   logic                s1_valid, s2_ready;
   logic                req_accept;
   logic [SEG_W-1:0]    segment_pattern;
   logic [ENABLE_W-1:0] digit_enable;
   logic [COUNT_W-1:0]  count_now;
   logic                save_request;
   logic                load_accept;
   logic                tick_accept;
   logic [COUNT_W-1:0]  count_prev_ff;
   logic                count_step_ok;
   logic                count_range_ok;

   ducs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ducs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .up_level   (req_tdata[0]),
      .down_level (req_tdata[1]),
      .load_value (req_tdata[2 +: LOAD_W]),
      .s2_ready   (s2_ready),
      .s1_valid   (s1_valid),
      .s1_data    (s1_data),
      .stat       (stat)
   );

   ducs_digit u_digit (
      .clock           (clock),
      .reset           (reset),
      .s1_valid        (s1_valid),
      .s1_data         (s1_data),
      .s1_ready        (s2_ready),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .segment_pattern (segment_pattern),
      .digit_enable    (digit_enable),
      .count_now       (count_now),
      .save_request    (save_request)
   );

   assign rsp_tdata = RSP_DATA_W'({save_request, count_now, digit_enable, segment_pattern});

   assign req_accept     = req_tvalid && req_tready;
   assign load_accept    = req_accept && (req_tuser == REQ_LOAD);
   assign tick_accept    = req_accept && (req_tuser == REQ_TICK);
   assign count_step_ok  = (stat.count == count_prev_ff) ||
                           (stat.count == count_prev_ff + COUNT_W'(1)) ||
                           (stat.count == count_prev_ff - COUNT_W'(1));
   assign count_range_ok = (count_now <= COUNT_MAX) && (stat.count <= COUNT_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_prev_ff <= '0;
      end else begin
         count_prev_ff <= stat.count;
      end
   end

   // count moves only when a word is taken
   `DUCS_ASSERT_NEXT(a_count_idle, clock, reset, !req_accept, $stable(stat.count))
   // a load always leaves an update pending for the scanner
   `DUCS_ASSERT_NEXT(a_load_pends, clock, reset, load_accept, stat.pending)
   // a tick moves the count by at most one
   `DUCS_ASSERT_NEXT(a_tick_step, clock, reset, tick_accept, count_step_ok)
   // count stays within four decimal digits
   `DUCS_ASSERT_NOW(a_count_range, clock, reset, rsp_tvalid, count_range_ok)

endmodule
`default_nettype wire

### hw/rtl/ducs_csr.sv
// register port for the debounce and scan periods
`default_nettype none
module ducs_csr import ducs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index_type'(csr_paddr[2]))
            REG_DEBOUNCE: cfg_in.debounce_ticks = csr_pwdata[TICKS_W-1:0];
            REG_SCAN:     cfg_in.scan_ticks     = csr_pwdata[TICKS_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[2]))
         REG_DEBOUNCE: csr_prdata = CSR_DATA_W'(cfg_ff.debounce_ticks);
         REG_SCAN:     csr_prdata = CSR_DATA_W'(cfg_ff.scan_ticks);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.scan_ticks     <= SCAN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/ducs_debounce.sv
// press and release debounce of one active-low button
`default_nettype none
module ducs_debounce import ducs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               level,
   input  wire logic [TICKS_W-1:0] ticks,
   output logic                    confirm
);

   phase_type          phase_ff, phase_in;
   logic [TICKS_W-1:0] cd_ff, cd_in;
   logic               pressed;

   assign pressed = !level;

   always_comb begin
      phase_in = phase_ff;
      cd_in    = cd_ff;
      confirm  = 1'b0;
      unique case (phase_ff) inside
         PH_RELEASED: begin
            if (pressed) begin
               phase_in = PH_PRESS_CHECK;
               cd_in    = ticks;
            end
         end
         PH_PRESSED: begin
            if (!pressed) begin
               phase_in = PH_RELEASE_CHECK;
               cd_in    = ticks;
            end
         end
         PH_PRESS_CHECK, PH_RELEASE_CHECK: begin
            if (cd_ff > TICKS_W'(1)) begin
               cd_in = cd_ff - TICKS_W'(1);
            end else begin
               cd_in    = '0;
               phase_in = pressed ? PH_PRESSED : PH_RELEASED;
               confirm  = pressed && (phase_ff == PH_PRESS_CHECK);
            end
         end
         default: begin
            phase_in = PH_RELEASED;
            cd_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASED;
         cd_ff    <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cd_ff    <= cd_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/ducs_ctrl.sv
// count, pending update and scan state, first pipeline register
`default_nettype none
module ducs_ctrl import ducs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_kind,
   input  wire logic              up_level,
   input  wire logic              down_level,
   input  wire logic [LOAD_W-1:0] load_value,
   input  wire logic              s2_ready,
   output logic                   s1_valid,
   output s1_type                 s1_data,
   output stat_type               stat
);

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                pend_ff, pend_in;
   logic [TICKS_W-1:0]  scd_ff, scd_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [COUNT_W-1:0]  disp_count_ff, disp_count_in;
   logic                disp_lit_ff, disp_lit_in;
   logic [COUNT_W-1:0]  sh_count_ff, sh_count_in;
   logic                sh_lit_ff, sh_lit_in;
   logic [POS_W-1:0]    sh_pos_ff, sh_pos_in;
   logic [ENABLE_W-1:0] sh_en_ff, sh_en_in;
   logic                s1_valid_ff;
   s1_type              s1_ff, s1_in;

   logic               accept, is_load, tick_step;
   logic               up_confirm, down_confirm, up_ok, dn_ok;
   logic [COUNT_W-1:0] count_up, count_tick, load_count;
   logic               pend_mid, scan_step;
   logic [POS_W-1:0]   pos_eff;

   assign req_ready = !s1_valid_ff || s2_ready;
   assign accept    = req_valid && req_ready;
   assign is_load   = (req_kind == REQ_LOAD);
   assign tick_step = accept && !is_load;

   ducs_debounce u_up (
      .clock   (clock),
      .reset   (reset),
      .step    (tick_step),
      .level   (up_level),
      .ticks   (cfg.debounce_ticks),
      .confirm (up_confirm)
   );

   ducs_debounce u_down (
      .clock   (clock),
      .reset   (reset),
      .step    (tick_step),
      .level   (down_level),
      .ticks   (cfg.debounce_ticks),
      .confirm (down_confirm)
   );

   always_comb begin
      up_ok      = up_confirm && (count_ff < COUNT_MAX);
      count_up   = up_ok ? count_ff + COUNT_W'(1) : count_ff;
      dn_ok      = down_confirm && (count_up != '0);
      count_tick = dn_ok ? count_up - COUNT_W'(1) : count_up;
      load_count = (load_value > LOAD_W'(COUNT_MAX)) ? '0 : load_value[COUNT_W-1:0];
      pend_mid   = pend_ff || up_ok || dn_ok;
      scan_step  = (scd_ff <= TICKS_W'(1));
      pos_eff    = (int'(pos_ff) >= DIGIT_COUNT) ? '0 : pos_ff;

      count_in      = count_ff;
      pend_in       = pend_ff;
      scd_in        = scd_ff;
      pos_in        = pos_ff;
      disp_count_in = disp_count_ff;
      disp_lit_in   = disp_lit_ff;
      sh_count_in   = sh_count_ff;
      sh_lit_in     = sh_lit_ff;
      sh_pos_in     = sh_pos_ff;
      sh_en_in      = sh_en_ff;

      if (accept) begin
         if (is_load) begin
            count_in = load_count;
            pend_in  = 1'b1;
         end else begin
            count_in = count_tick;
            pend_in  = pend_mid;
            if (!scan_step) begin
               scd_in = scd_ff - TICKS_W'(1);
            end else begin
               scd_in = cfg.scan_ticks;
               if (pend_mid) begin
                  disp_count_in = count_tick;
                  disp_lit_in   = 1'b1;
                  pend_in       = 1'b0;
               end
               sh_count_in = pend_mid ? count_tick : disp_count_ff;
               sh_lit_in   = pend_mid || disp_lit_ff;
               sh_pos_in   = pos_eff;
               sh_en_in    = (int'(pos_eff) < ENABLE_W) ? (ENABLE_W'(1) << pos_eff) : '0;
               pos_in      = (pos_eff == POS_LAST) ? '0 : pos_eff + POS_W'(1);
            end
         end
      end

      s1_in.count  = count_in;
      s1_in.save   = tick_step && (up_ok || dn_ok);
      s1_in.lit    = sh_lit_in;
      s1_in.pos    = sh_pos_in;
      s1_in.enable = sh_en_in;
      s1_in.shown  = sh_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         scd_ff        <= '0;
         pos_ff        <= '0;
         disp_count_ff <= '0;
         disp_lit_ff   <= 1'b0;
         sh_count_ff   <= '0;
         sh_lit_ff     <= 1'b0;
         sh_pos_ff     <= '0;
         sh_en_ff      <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         scd_ff        <= scd_in;
         pos_ff        <= pos_in;
         disp_count_ff <= disp_count_in;
         disp_lit_ff   <= disp_lit_in;
         sh_count_ff   <= sh_count_in;
         sh_lit_ff     <= sh_lit_in;
         sh_pos_ff     <= sh_pos_in;
         sh_en_ff      <= sh_en_in;
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_ff;
   assign stat     = '{count: count_ff, pending: pend_ff};

endmodule
`default_nettype wire

### hw/rtl/ducs_digit.sv
// digit extraction and segment lookup, result register
`default_nettype none
module ducs_digit import ducs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  s1_valid,
   input  wire s1_type                s1_data,
   output logic                       s1_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [SEG_W-1:0]      segment_pattern,
   output logic      [ENABLE_W-1:0]   digit_enable,
   output logic      [COUNT_W-1:0]    count_now,
   output logic                       save_request
);

   localparam int PROD_W  = COUNT_W + RECIP_W;
   localparam int QPROD_W = COUNT_W + DIV10_W;

   s2_type              s2_ff, s2_in;
   logic                s2_valid_ff;
   logic                out_valid_ff;
   logic [SEG_W-1:0]    seg_ff, seg_in;
   logic [ENABLE_W-1:0] en_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                save_ff;

   logic                out_ready;
   logic [PROD_W-1:0]   prod;
   logic [QPROD_W-1:0]  qprod;
   logic [3:0]          q10_low, digit;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign s1_ready  = !s2_valid_ff || out_ready;

   // shown count divided by the power of ten of its position
   always_comb begin
      prod         = PROD_W'(s1_data.shown) * PROD_W'(recip_of(s1_data.pos));
      s2_in.count  = s1_data.count;
      s2_in.save   = s1_data.save;
      s2_in.lit    = s1_data.lit;
      s2_in.enable = s1_data.enable;
      s2_in.quot   = prod[RECIP_SHIFT +: COUNT_W];
   end

   // quotient modulo ten, only the low nibble matters
   always_comb begin
      qprod   = QPROD_W'(s2_ff.quot) * QPROD_W'(DIV10_RECIP);
      q10_low = qprod[DIV10_SHIFT +: 4];
      digit   = s2_ff.quot[3:0] - ((q10_low << 3) + (q10_low << 1));
      seg_in  = s2_ff.lit ? seg_of(digit) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s2_valid_ff <= s1_valid;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s2_ff <= s2_in;
      end
      if (out_ready) begin
         seg_ff   <= seg_in;
         en_ff    <= s2_ff.enable;
         count_ff <= s2_ff.count;
         save_ff  <= s2_ff.save;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign segment_pattern = seg_ff;
   assign digit_enable    = en_ff;
   assign count_now       = count_ff;
   assign save_request    = save_ff;

endmodule
`default_nettype wire
